// ===== hw/rtl/hover_position_pid_to_attitude_defines.svh =====
// Assertion macros for the hover position PID checker.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef HOVER_POSITION_PID_TO_ATTITUDE_DEFINES_SVH
`define HOVER_POSITION_PID_TO_ATTITUDE_DEFINES_SVH

// Same-cycle implication.
`define HPA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HPA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/hpa_pkg.sv =====
// Shared types and constants for the hover position PID block.
// No dependencies; every RTL module in the other files imports this package.
package hpa_pkg;

  // Fraction bits of heading sine and cosine; the body rotation drops two fewer.
  localparam int TRIG_FRAC = 14;
  localparam int ROT_SHIFT = TRIG_FRAC - 2;

  typedef enum logic [1:0] {
    OP_RUN     = 2'd0,
    OP_CAPTURE = 2'd1,
    OP_LOAD    = 2'd2
  } opcode_t;

  localparam logic [2:0] CFG_PROP_GAIN      = 3'd0;
  localparam logic [2:0] CFG_DERIV_GAIN     = 3'd1;
  localparam logic [2:0] CFG_INTEG_GAIN     = 3'd2;
  localparam logic [2:0] CFG_POS_ERR_LIMIT  = 3'd3;
  localparam logic [2:0] CFG_SPEED_LIMIT    = 3'd4;
  localparam logic [2:0] CFG_BANK_LIMIT     = 3'd5;
  localparam logic [2:0] CFG_HEADING_TARGET = 3'd6;
  localparam logic [2:0] CFG_HALF_TURN      = 3'd7;

  localparam logic [20:0] POS_ERR_LIMIT_RST = 21'd4096;
  localparam logic [24:0] SPEED_LIMIT_RST   = 25'd8388608;
  localparam logic [20:0] BANK_LIMIT_RST    = 21'd65536;
  localparam logic [22:0] HALF_TURN_RST     = 23'd3294199;

  typedef struct packed {
    logic start;
    logic load_hold;
    logic clear_integ;
  } lane_ctrl_t;

  typedef enum logic [2:0] {
    LN_IDLE,
    LN_ERR,
    LN_INT,
    LN_MD,
    LN_MI,
    LN_SUM,
    LN_CLAMP
  } lane_state_t;

  typedef enum logic [2:0] {
    RT_IDLE,
    RT_M0,
    RT_M1,
    RT_M2,
    RT_M3,
    RT_ACC,
    RT_OUT
  } rot_state_t;

  typedef enum logic [1:0] {
    YW_IDLE,
    YW_PREP,
    YW_DIV,
    YW_FIX
  } yaw_state_t;

  typedef enum logic [1:0] {
    TP_IDLE,
    TP_AXIS,
    TP_ROTATE,
    TP_OUTPUT
  } top_state_t;

endpackage

// ===== hw/rtl/hpa_axis_lane.sv =====
// One axis of the hover PID: error clamp, saturating integral and a
// sequenced multiply-accumulate of the three terms. Depends on hpa_pkg.
module hpa_axis_lane (
  input  logic                     clk,
  input  logic                     rst_n,
  input  hpa_pkg::lane_ctrl_t      ctrl,
  input  logic signed [31:0]       pos,
  input  logic signed [31:0]       vel,
  input  logic [15:0]              prop_gain,
  input  logic [15:0]              deriv_gain,
  input  logic [15:0]              integ_gain,
  input  logic [20:0]              pos_err_limit,
  input  logic [24:0]              speed_limit,
  input  logic [20:0]              bank_limit,
  input  logic [24:0]              sum_limit,
  output logic                     busy,
  output logic signed [21:0]       cmd
);
  import hpa_pkg::*;

  lane_state_t        state_r, state_nxt;
  logic signed [31:0] hold_r, hold_nxt;
  logic signed [25:0] integ_r, integ_nxt;

  logic signed [31:0] pos_r, vel_r;
  logic signed [21:0] err_r;
  logic signed [16:0] vsh_r;
  logic signed [39:0] prod_r;
  logic signed [40:0] acc_r;
  logic signed [21:0] cmd_r;

  logic signed [32:0] diff_c, elim_c, vin_c, vlim_c;
  logic signed [21:0] err_c;
  logic signed [25:0] vcl_c;
  logic signed [26:0] isum_c, ilim_c;
  logic signed [25:0] icl_c;
  logic [16:0]        mul_a;
  logic signed [21:0] mul_b;
  logic signed [39:0] prod_c;
  logic signed [40:0] acc_sum_c, blim_c;
  logic signed [21:0] cmd_c;

  // Position error and speed clamps.
  always_comb begin
    diff_c = $signed({pos_r[31], pos_r}) - $signed({hold_r[31], hold_r});
    elim_c = $signed({12'd0, pos_err_limit});
    if (diff_c > elim_c) begin
      err_c = elim_c[21:0];
    end else if (diff_c < -elim_c) begin
      err_c = 22'(-elim_c);
    end else begin
      err_c = diff_c[21:0];
    end

    vin_c  = $signed({vel_r[31], vel_r});
    vlim_c = $signed({8'd0, speed_limit});
    if (vin_c > vlim_c) begin
      vcl_c = vlim_c[25:0];
    end else if (vin_c < -vlim_c) begin
      vcl_c = 26'(-vlim_c);
    end else begin
      vcl_c = vin_c[25:0];
    end
  end

  // Saturating integral.
  always_comb begin
    isum_c = $signed({integ_r[25], integ_r}) + $signed({{5{err_r[21]}}, err_r});
    ilim_c = $signed({2'd0, sum_limit});
    if (isum_c > ilim_c) begin
      icl_c = ilim_c[25:0];
    end else if (isum_c < -ilim_c) begin
      icl_c = 26'(-ilim_c);
    end else begin
      icl_c = isum_c[25:0];
    end
  end

  // Shared multiplier: doubled P gain, then D, then I.
  always_comb begin
    case (state_r)
      LN_INT: begin
        mul_a = {prop_gain, 1'b0};
        mul_b = err_r;
      end
      LN_MD: begin
        mul_a = {1'b0, deriv_gain};
        mul_b = {{5{vsh_r[16]}}, vsh_r};
      end
      LN_MI: begin
        mul_a = {1'b0, integ_gain};
        mul_b = {{8{integ_r[25]}}, integ_r[25:12]};
      end
      default: begin
        mul_a = {prop_gain, 1'b0};
        mul_b = err_r;
      end
    endcase
    prod_c = $signed({1'b0, mul_a}) * mul_b;
  end

  always_comb begin
    acc_sum_c = acc_r + $signed({prod_r[39], prod_r});
    blim_c    = $signed({20'd0, bank_limit});
    if (acc_r > blim_c) begin
      cmd_c = blim_c[21:0];
    end else if (acc_r < -blim_c) begin
      cmd_c = 22'(-blim_c);
    end else begin
      cmd_c = acc_r[21:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    hold_nxt  = hold_r;
    integ_nxt = integ_r;
    if (ctrl.load_hold) begin
      hold_nxt = pos;
    end
    if (ctrl.clear_integ) begin
      integ_nxt = '0;
    end
    case (state_r)
      LN_IDLE: begin
        if (ctrl.start) begin
          state_nxt = LN_ERR;
        end
      end
      LN_ERR:   state_nxt = LN_INT;
      LN_INT: begin
        integ_nxt = icl_c;
        state_nxt = LN_MD;
      end
      LN_MD:    state_nxt = LN_MI;
      LN_MI:    state_nxt = LN_SUM;
      LN_SUM:   state_nxt = LN_CLAMP;
      LN_CLAMP: state_nxt = LN_IDLE;
      default:  state_nxt = LN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LN_IDLE;
      hold_r  <= '0;
      integ_r <= '0;
    end else begin
      state_r <= state_nxt;
      hold_r  <= hold_nxt;
      integ_r <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      pos_r <= pos;
      vel_r <= vel;
    end
    case (state_r)
      LN_ERR: begin
        err_r <= err_c;
        vsh_r <= vcl_c[25:9];
      end
      LN_INT: begin
        prod_r <= prod_c;
        acc_r  <= '0;
      end
      LN_MD, LN_MI: begin
        prod_r <= prod_c;
        acc_r  <= acc_sum_c;
      end
      LN_SUM:   acc_r <= acc_sum_c;
      LN_CLAMP: cmd_r <= cmd_c;
      default: ;
    endcase
  end

  assign busy = (state_r != LN_IDLE);
  assign cmd  = cmd_r;

endmodule

// ===== hw/rtl/hpa_yaw_wrap.sv =====
// Yaw setpoint: heading target plus stick yaw, wrapped into +-half_turn
// by a radix-4 restoring remainder unit. Depends on hpa_pkg.
module hpa_yaw_wrap (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [22:0] stick_yaw,
  input  logic signed [22:0] heading_target,
  input  logic [22:0]        half_turn,
  output logic               busy,
  output logic signed [23:0] yaw_cmd
);
  import hpa_pkg::*;

  localparam int DVD_W = 26;
  localparam int STEPS = DVD_W / 2;

  yaw_state_t         state_r, state_nxt;
  logic [3:0]         cnt_r, cnt_nxt;

  logic signed [23:0] ang_r;
  logic [22:0]        h_r;
  logic               hi_r, lo_r;
  logic [DVD_W-1:0]   dvd_r;
  logic [23:0]        rem_r;
  logic signed [23:0] yaw_r;

  logic [23:0]        p_c;
  logic signed [23:0] hs_c;
  logic signed [25:0] base_c;
  logic               hi_c, lo_c;
  logic [DVD_W-1:0]   dvd_c, dvd_step_c;
  logic [23:0]        rem_step_c;
  logic signed [25:0] res_c;

  always_comb begin
    p_c    = {h_r, 1'b0};
    hs_c   = $signed({1'b0, h_r});
    hi_c   = ang_r > hs_c;
    lo_c   = ang_r < -hs_c;
    base_c = $signed({{2{ang_r[23]}}, ang_r}) + $signed({3'd0, h_r});
    if (hi_c) begin
      dvd_c = DVD_W'(base_c - 26'sd1);
    end else begin
      dvd_c = DVD_W'(-base_c);
    end
  end

  // Two dividend bits per cycle.
  always_comb begin
    logic [24:0]      sh;
    logic [DVD_W-1:0] dv;
    logic [23:0]      rm;
    dv = dvd_r;
    rm = rem_r;
    for (int k = 0; k < 2; k++) begin
      sh = {rm, dv[DVD_W-1]};
      dv = {dv[DVD_W-2:0], 1'b0};
      if (sh >= {1'b0, p_c}) begin
        sh = sh - {1'b0, p_c};
      end
      rm = sh[23:0];
    end
    dvd_step_c = dv;
    rem_step_c = rm;
  end

  always_comb begin
    if (hi_r) begin
      res_c = $signed({2'd0, rem_r}) + 26'sd1 - $signed({3'd0, h_r});
    end else if (lo_r) begin
      if (rem_r == '0) begin
        res_c = -$signed({3'd0, h_r});
      end else begin
        res_c = $signed({2'd0, p_c}) - $signed({2'd0, rem_r}) - $signed({3'd0, h_r});
      end
    end else begin
      res_c = $signed({{2{ang_r[23]}}, ang_r});
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      YW_IDLE: begin
        if (start) begin
          state_nxt = YW_PREP;
        end
      end
      YW_PREP: begin
        cnt_nxt   = '0;
        state_nxt = YW_DIV;
      end
      YW_DIV: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(STEPS - 1)) begin
          state_nxt = YW_FIX;
        end
      end
      YW_FIX:  state_nxt = YW_IDLE;
      default: state_nxt = YW_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= YW_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ang_r <= 24'(heading_target) + 24'(stick_yaw);
      h_r   <= (half_turn == '0) ? 23'd1 : half_turn;
    end
    case (state_r)
      YW_PREP: begin
        hi_r  <= hi_c;
        lo_r  <= lo_c;
        dvd_r <= dvd_c;
        rem_r <= '0;
      end
      YW_DIV: begin
        dvd_r <= dvd_step_c;
        rem_r <= rem_step_c;
      end
      YW_FIX: yaw_r <= res_c[23:0];
      default: ;
    endcase
  end

  assign busy    = (state_r != YW_IDLE);
  assign yaw_cmd = yaw_r;

endmodule

// ===== hw/rtl/hpa_body_rotate.sv =====
// Merge stage: rotates the two earth-frame lane commands into roll and
// pitch with one shared multiplier, adds stick offsets and saturates.
module hpa_body_rotate (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] sin_v,
  input  logic signed [15:0] cos_v,
  input  logic signed [21:0] cmd_x,
  input  logic signed [21:0] cmd_y,
  input  logic signed [22:0] stick_roll,
  input  logic signed [22:0] stick_pitch,
  output logic               busy,
  output logic signed [31:0] roll_cmd,
  output logic signed [31:0] pitch_cmd
);
  import hpa_pkg::*;

  localparam logic signed [40:0] S32_MAX = 41'sd2147483647;
  localparam logic signed [40:0] S32_MIN = -41'sd2147483648;

  rot_state_t         state_r, state_nxt;

  logic signed [37:0] prod_r;
  logic signed [39:0] phi_r, theta_r;
  logic signed [31:0] roll_r, pitch_r;

  logic signed [15:0] trig_c;
  logic signed [21:0] cmd_c;
  logic signed [37:0] prod_c;
  logic signed [39:0] prod_ext_c, phi_sh_c, theta_sh_c;
  logic signed [40:0] phi_sum_c, theta_sum_c;

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    if (v > S32_MAX) begin
      return S32_MAX[31:0];
    end else if (v < S32_MIN) begin
      return S32_MIN[31:0];
    end
    return v[31:0];
  endfunction

  always_comb begin
    case (state_r)
      RT_M0: begin
        trig_c = sin_v;
        cmd_c  = cmd_x;
      end
      RT_M1: begin
        trig_c = cos_v;
        cmd_c  = cmd_y;
      end
      RT_M2: begin
        trig_c = cos_v;
        cmd_c  = cmd_x;
      end
      RT_M3: begin
        trig_c = sin_v;
        cmd_c  = cmd_y;
      end
      default: begin
        trig_c = sin_v;
        cmd_c  = cmd_x;
      end
    endcase
    prod_c      = trig_c * cmd_c;
    prod_ext_c  = {{2{prod_r[37]}}, prod_r};
    phi_sh_c    = phi_r >>> ROT_SHIFT;
    theta_sh_c  = theta_r >>> ROT_SHIFT;
    phi_sum_c   = $signed({phi_sh_c[39], phi_sh_c}) + $signed({{18{stick_roll[22]}}, stick_roll});
    theta_sum_c = $signed({theta_sh_c[39], theta_sh_c})
                + $signed({{18{stick_pitch[22]}}, stick_pitch});
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      RT_IDLE: begin
        if (start) begin
          state_nxt = RT_M0;
        end
      end
      RT_M0:   state_nxt = RT_M1;
      RT_M1:   state_nxt = RT_M2;
      RT_M2:   state_nxt = RT_M3;
      RT_M3:   state_nxt = RT_ACC;
      RT_ACC:  state_nxt = RT_OUT;
      RT_OUT:  state_nxt = RT_IDLE;
      default: state_nxt = RT_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RT_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // phi = c*y - s*x, theta = -(c*x + s*y)
  always_ff @(posedge clk) begin
    case (state_r)
      RT_M0: prod_r <= prod_c;
      RT_M1: begin
        phi_r  <= -prod_ext_c;
        prod_r <= prod_c;
      end
      RT_M2: begin
        phi_r  <= phi_r + prod_ext_c;
        prod_r <= prod_c;
      end
      RT_M3: begin
        theta_r <= -prod_ext_c;
        prod_r  <= prod_c;
      end
      RT_ACC: theta_r <= theta_r - prod_ext_c;
      RT_OUT: begin
        roll_r  <= sat32(phi_sum_c);
        pitch_r <= sat32(theta_sum_c);
      end
      default: ;
    endcase
  end

  assign busy      = (state_r != RT_IDLE);
  assign roll_cmd  = roll_r;
  assign pitch_cmd = pitch_r;

endmodule

// ===== hw/rtl/hover_position_pid_to_attitude.sv =====
// Hover position PID to attitude setpoints. In a run transaction (opcode
// run) the yaw wrap remainder unit (2 dividend bits a cycle over a 26-bit
// dividend, plus setup and fix-up states) runs beside the two axis lanes
// (each sequenced on its own shared multiplier), after which the body
// rotation stage (one multiplier) must also finish before the result is
// valid. The next transaction is taken once the result sits in the output
// register, even if the consumer is still stalling it. Capture and
// load-setpoint transactions never make the block busy and give no result;
// opcode 3 is dropped. Write configuration only while the block is idle.
// Depends on hpa_pkg, hpa_axis_lane, hpa_yaw_wrap and hpa_body_rotate.
module hover_position_pid_to_attitude (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [15:0] in_heading_sin,
  input  logic signed [15:0] in_heading_cos,
  input  logic signed [22:0] in_stick_roll,
  input  logic signed [22:0] in_stick_pitch,
  input  logic signed [22:0] in_stick_yaw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_roll_cmd,
  output logic signed [31:0] out_pitch_cmd,
  output logic signed [23:0] out_yaw_cmd,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [24:0]        cfg_wdata
);
  import hpa_pkg::*;

  logic [15:0]        prop_gain_r, deriv_gain_r, integ_gain_r;
  logic [20:0]        pos_err_limit_r, bank_limit_r;
  logic [24:0]        speed_limit_r;
  logic signed [22:0] heading_target_r;
  logic [22:0]        half_turn_r;

  top_state_t         state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic signed [15:0] sin_r, cos_r;
  logic signed [22:0] stick_roll_r, stick_pitch_r;
  logic signed [31:0] roll_r, pitch_r;
  logic signed [23:0] yaw_r;

  logic               in_accept;
  opcode_t            op;
  lane_ctrl_t         lane_ctrl;
  logic               rot_start, out_load;
  logic [24:0]        sum_limit;
  logic               lane_x_busy, lane_y_busy, rot_busy, yaw_busy;
  logic signed [21:0] cmd_x, cmd_y;
  logic signed [31:0] rot_roll, rot_pitch;
  logic signed [23:0] yaw_cmd;

  assign in_accept = in_valid && !in_stall;
  assign op        = opcode_t'(in_opcode);
  assign in_stall  = (state_r != TP_IDLE);

  // Integral bound: pos_err_limit << 12, capped to fit the 26-bit store.
  assign sum_limit = (|pos_err_limit_r[20:13]) ? 25'h1FF_FFFF
                                               : {pos_err_limit_r[12:0], 12'd0};

  always_comb begin
    lane_ctrl = '0;
    if (in_accept) begin
      case (op)
        OP_RUN:     lane_ctrl.start = 1'b1;
        OP_CAPTURE: begin
          lane_ctrl.load_hold   = 1'b1;
          lane_ctrl.clear_integ = 1'b1;
        end
        OP_LOAD:    lane_ctrl.load_hold = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r      <= '0;
      deriv_gain_r     <= '0;
      integ_gain_r     <= '0;
      pos_err_limit_r  <= POS_ERR_LIMIT_RST;
      speed_limit_r    <= SPEED_LIMIT_RST;
      bank_limit_r     <= BANK_LIMIT_RST;
      heading_target_r <= '0;
      half_turn_r      <= HALF_TURN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROP_GAIN:      prop_gain_r      <= cfg_wdata[15:0];
        CFG_DERIV_GAIN:     deriv_gain_r     <= cfg_wdata[15:0];
        CFG_INTEG_GAIN:     integ_gain_r     <= cfg_wdata[15:0];
        CFG_POS_ERR_LIMIT:  pos_err_limit_r  <= cfg_wdata[20:0];
        CFG_SPEED_LIMIT:    speed_limit_r    <= cfg_wdata[24:0];
        CFG_BANK_LIMIT:     bank_limit_r     <= cfg_wdata[20:0];
        CFG_HEADING_TARGET: heading_target_r <= $signed(cfg_wdata[22:0]);
        CFG_HALF_TURN:      half_turn_r      <= cfg_wdata[22:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    rot_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      TP_IDLE: begin
        if (lane_ctrl.start) begin
          state_nxt = TP_AXIS;
        end
      end
      TP_AXIS: begin
        if (!lane_x_busy && !lane_y_busy) begin
          rot_start = 1'b1;
          state_nxt = TP_ROTATE;
        end
      end
      TP_ROTATE: begin
        if (!rot_busy && !yaw_busy) begin
          state_nxt = TP_OUTPUT;
        end
      end
      TP_OUTPUT: begin
        // Hold until the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = TP_IDLE;
        end
      end
      default: state_nxt = TP_IDLE;
    endcase
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= TP_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (lane_ctrl.start) begin
      sin_r         <= in_heading_sin;
      cos_r         <= in_heading_cos;
      stick_roll_r  <= in_stick_roll;
      stick_pitch_r <= in_stick_pitch;
    end
    if (out_load) begin
      roll_r  <= rot_roll;
      pitch_r <= rot_pitch;
      yaw_r   <= yaw_cmd;
    end
  end

  hpa_axis_lane u_lane_x (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (lane_ctrl),
    .pos           (in_pos_x),
    .vel           (in_vel_x),
    .prop_gain     (prop_gain_r),
    .deriv_gain    (deriv_gain_r),
    .integ_gain    (integ_gain_r),
    .pos_err_limit (pos_err_limit_r),
    .speed_limit   (speed_limit_r),
    .bank_limit    (bank_limit_r),
    .sum_limit     (sum_limit),
    .busy          (lane_x_busy),
    .cmd           (cmd_x)
  );

  hpa_axis_lane u_lane_y (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (lane_ctrl),
    .pos           (in_pos_y),
    .vel           (in_vel_y),
    .prop_gain     (prop_gain_r),
    .deriv_gain    (deriv_gain_r),
    .integ_gain    (integ_gain_r),
    .pos_err_limit (pos_err_limit_r),
    .speed_limit   (speed_limit_r),
    .bank_limit    (bank_limit_r),
    .sum_limit     (sum_limit),
    .busy          (lane_y_busy),
    .cmd           (cmd_y)
  );

  hpa_yaw_wrap u_yaw (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (lane_ctrl.start),
    .stick_yaw      (in_stick_yaw),
    .heading_target (heading_target_r),
    .half_turn      (half_turn_r),
    .busy           (yaw_busy),
    .yaw_cmd        (yaw_cmd)
  );

  hpa_body_rotate u_rotate (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (rot_start),
    .sin_v       (sin_r),
    .cos_v       (cos_r),
    .cmd_x       (cmd_x),
    .cmd_y       (cmd_y),
    .stick_roll  (stick_roll_r),
    .stick_pitch (stick_pitch_r),
    .busy        (rot_busy),
    .roll_cmd    (rot_roll),
    .pitch_cmd   (rot_pitch)
  );

  assign out_valid     = out_valid_r;
  assign out_roll_cmd  = roll_r;
  assign out_pitch_cmd = pitch_r;
  assign out_yaw_cmd   = yaw_r;

endmodule

// ===== hw/rtl/hpa_checker.sv =====
// Port-level checker for the hover position PID block, bound to the top.
// Depends on hpa_pkg and the assertion macro header.
`include "hover_position_pid_to_attitude_defines.svh"

module hpa_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         in_opcode,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_roll_cmd,
  input logic signed [31:0] out_pitch_cmd,
  input logic signed [23:0] out_yaw_cmd
);
  import hpa_pkg::*;

  `HPA_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                  out_valid && $stable(out_roll_cmd) && $stable(out_pitch_cmd)
                  && $stable(out_yaw_cmd), "stalled result transaction changed")
  `HPA_ASSERT_NXT(a_run_busy, in_valid && !in_stall && in_opcode == OP_RUN, in_stall,
                  "run transaction did not make the block busy")
  `HPA_ASSERT_NXT(a_setpoint_quick, in_valid && !in_stall && in_opcode != OP_RUN,
                  !in_stall, "setpoint transaction stalled the input")
  `HPA_ASSERT_IMP(a_result_from_run, $rose(out_valid), $past(in_stall),
                  "result appeared without a run in progress")

endmodule

bind hover_position_pid_to_attitude hpa_checker u_hpa_checker (.*);
